[rtl/priority_collection_table_assert.svh]
// Assertion macros shared by the priority collection table RTL.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef PRIORITY_COLLECTION_TABLE_ASSERT_SVH
`define PRIORITY_COLLECTION_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pct_pkg.sv]
// Package for the priority collection table: item types, codes and defaults.
// Used by the top level of the block; depends on nothing.
package pct_pkg;

  // Default sizes of the table.
  localparam int ENTRIES_DEFAULT        = 64;
  localparam int PAYLOAD_WIDTH_DEFAULT  = 32;
  localparam int PRIORITY_WIDTH_DEFAULT = 16;
  localparam int ID_WIDTH_DEFAULT       = 32;

  // Operation codes.
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_PROMOTE = 3'd1;
  localparam logic [2:0] OP_LOOKUP  = 3'd2;
  localparam logic [2:0] OP_GET_MAX = 3'd3;
  localparam logic [2:0] OP_POP_MAX = 3'd4;

  // Status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

  // One command item.
  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] payload_in;
    logic [31:0] target_id;
  } request_t;

  // One result item.
  typedef struct packed {
    logic [31:0] assigned_id;
    logic [31:0] payload_out;
    logic [15:0] priority_out;
    logic        present;
    logic [1:0]  status;
  } result_t;

endpackage

[rtl/pct_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; holds the slot table of the priority collection table.
module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/priority_collection_table.sv]
// Top level of the priority collection table: sequencer, scan unit, results.
// Depends on pct_pkg, pct_ram and priority_collection_table_assert.svh.
//
//   channel   ports                  handshake
//   --------  ---------------------  ------------------------------------
//   command   request, start, busy   taken when start is high, busy low
//   result    result, done           valid for the single cycle done is high
//
// Every item scans the whole slot table through one RAM read port, one slot
// per cycle, with one shared compare unit: busy stays high through the scan,
// the drain step and the finishing step, and the result shows in the cycle
// after finishing. After reset a clearing pass writes every slot as free,
// with busy high. The receiver cannot stall; each result is shown exactly once.
`include "priority_collection_table_assert.svh"

module priority_collection_table #(
  parameter int ENTRIES        = pct_pkg::ENTRIES_DEFAULT,
  parameter int PAYLOAD_WIDTH  = pct_pkg::PAYLOAD_WIDTH_DEFAULT,
  parameter int PRIORITY_WIDTH = pct_pkg::PRIORITY_WIDTH_DEFAULT,
  parameter int ID_WIDTH       = pct_pkg::ID_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pct_pkg::request_t request,
  output logic              done,
  output pct_pkg::result_t  result
);

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(ENTRIES - 1);

  // One slot of the table as stored in the RAM.
  typedef struct packed {
    logic                      used;
    logic [ID_WIDTH-1:0]       id;
    logic [PAYLOAD_WIDTH-1:0]  payload;
    logic [PRIORITY_WIDTH-1:0] prio;
  } slot_t;

  localparam int WORD_WIDTH = $bits(slot_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                   state;
  logic [AW-1:0]            cnt;
  logic                     rd_valid;
  logic [AW-1:0]            rd_idx;
  logic                     hit;
  logic [AW-1:0]            hit_idx;
  slot_t                    hit_word;
  logic [2:0]               op_reg;
  logic [PAYLOAD_WIDTH-1:0] pay_reg;
  logic [31:0]              target_reg;
  logic [ID_WIDTH-1:0]      next_id;
  pct_pkg::result_t         result_next;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic [WORD_WIDTH-1:0] ram_rdata;
  slot_t                 rd_word;
  slot_t                 wr_word;
  logic                  better;
  logic                  take;

  pct_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  assign busy    = (state != S_IDLE);
  assign rd_word = slot_t'(ram_rdata);

  // Shared compare unit: decides whether the slot just read replaces the hit.
  always_comb begin
    better = (rd_word.prio > hit_word.prio) ||
             ((rd_word.prio == hit_word.prio) && (rd_word.id > hit_word.id));
    unique case (op_reg)
      pct_pkg::OP_ADD: begin
        take = !rd_word.used && !hit;
      end
      pct_pkg::OP_PROMOTE, pct_pkg::OP_LOOKUP: begin
        take = rd_word.used && !hit && (32'(rd_word.id) == target_reg);
      end
      pct_pkg::OP_GET_MAX, pct_pkg::OP_POP_MAX: begin
        take = rd_word.used && (!hit || better);
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  // Table write and result of the finishing step; clearing pass after reset.
  always_comb begin
    wr_word     = hit_word;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx;
    result_next = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        wr_word   = '0;
      end
      S_FINISH: begin
        unique case (op_reg)
          pct_pkg::OP_ADD: begin
            if (hit) begin
              wr_word.used    = 1'b1;
              wr_word.id      = next_id;
              wr_word.payload = pay_reg;
              wr_word.prio    = '0;
              ram_we          = 1'b1;
              result_next.assigned_id = 32'(next_id);
            end else begin
              result_next.status = pct_pkg::STATUS_FULL;
            end
          end
          pct_pkg::OP_PROMOTE: begin
            if (hit) begin
              if (hit_word.prio != '1) begin
                wr_word.prio = PRIORITY_WIDTH'(hit_word.prio + 1'b1);
              end
              ram_we = 1'b1;
            end else begin
              result_next.status = pct_pkg::STATUS_UNKNOWN;
            end
          end
          pct_pkg::OP_LOOKUP: begin
            if (hit) begin
              result_next.present     = 1'b1;
              result_next.payload_out = 32'(hit_word.payload);
            end else begin
              result_next.status = pct_pkg::STATUS_UNKNOWN;
            end
          end
          pct_pkg::OP_GET_MAX, pct_pkg::OP_POP_MAX: begin
            if (hit) begin
              result_next.assigned_id  = 32'(hit_word.id);
              result_next.payload_out  = 32'(hit_word.payload);
              result_next.priority_out = 16'(hit_word.prio);
              if (op_reg == pct_pkg::OP_POP_MAX) begin
                wr_word.used = 1'b0;
                ram_we       = 1'b1;
              end
            end else begin
              result_next.status = pct_pkg::STATUS_EMPTY;
            end
          end
          default: begin
            result_next = '0;
          end
        endcase
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    ram_wdata = WORD_WIDTH'(wr_word);
  end

  // Sequencer: clearing pass, scan of every slot, drain, finishing step, result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      rd_valid <= 1'b0;
      hit      <= 1'b0;
      next_id  <= '0;
      done     <= 1'b0;
      result   <= '0;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      if (rd_valid && take) begin
        hit <= 1'b1;
      end
      unique case (state)
        S_CLEAR: begin
          if (cnt == LAST_SLOT) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            cnt   <= '0;
            hit   <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_valid <= 1'b1;
          if (cnt == LAST_SLOT) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (op_reg == pct_pkg::OP_ADD && hit) begin
            next_id <= ID_WIDTH'(next_id + 1'b1);
          end
          cnt    <= '0;
          result <= result_next;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: command fields, read tag and the current hit slot.
  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (state == S_IDLE && start) begin
      op_reg     <= request.operation;
      pay_reg    <= PAYLOAD_WIDTH'(request.payload_in);
      target_reg <= request.target_id;
    end
    if (rd_valid && take) begin
      hit_idx  <= rd_idx;
      hit_word <= rd_word;
    end
  end

  // A result follows the finishing step, and only it.
  `PCT_ASSERT_NEXT(a_done_after_finish, state == S_FINISH, done, "finish gave no result")
  `PCT_ASSERT_NOW(a_done_source, done, $past(state == S_FINISH), "result without finish")
  // An accepted item keeps the block busy on the next cycle.
  `PCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item left block idle")
  // A full table is reported by an add alone.
  `PCT_ASSERT_NOW(a_full_on_add, done && result.status == pct_pkg::STATUS_FULL,
                  op_reg == pct_pkg::OP_ADD, "full status on a non-add item")

endmodule
